### rtl/core/rthit_pkg.sv
`default_nettype none

package rthit_pkg;

  // Component and intermediate widths, all signed
  localparam int unsigned W_C = 16;        // Q8.8 input component
  localparam int unsigned W_E = W_C + 1;   // edge and origin offset
  localparam int unsigned W_H = 2 * W_C + 2; // dir x e2
  localparam int unsigned W_Q = 2 * W_E + 1; // s x e1
  localparam int unsigned W_P = W_E + W_Q + 1; // one dot-product term
  localparam int unsigned W_S = W_P + 3;   // sum of three terms
  localparam int unsigned W_T = W_S + 8;   // distance compare

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DET_EPS_W = 16;
  localparam int unsigned DIST_EPS_W = 8;

  // Register indexes (paddr bit 2)
  localparam logic REG_DET_EPS = 1'b0;
  localparam logic REG_DIST_EPS = 1'b1;

  localparam logic [DET_EPS_W-1:0] DET_EPS_RST = 16'd1;
  localparam logic [DIST_EPS_W-1:0] DIST_EPS_RST = 8'd1;

  // Packed vectors, x in the low bits
  typedef struct packed {
    logic signed [W_C-1:0] z;
    logic signed [W_C-1:0] y;
    logic signed [W_C-1:0] x;
  } vec_c_t;

  typedef struct packed {
    logic signed [W_E-1:0] z;
    logic signed [W_E-1:0] y;
    logic signed [W_E-1:0] x;
  } vec_e_t;

  typedef struct packed {
    logic signed [W_H-1:0] z;
    logic signed [W_H-1:0] y;
    logic signed [W_H-1:0] x;
  } vec_h_t;

  typedef struct packed {
    logic signed [W_Q-1:0] z;
    logic signed [W_Q-1:0] y;
    logic signed [W_Q-1:0] x;
  } vec_q_t;

endpackage

`default_nettype wire

### rtl/core/ray_triangle_hit_test_core.sv
`default_nettype none

// Ray/triangle hit test in exact integer arithmetic. Each input beat carries
// a ray (origin, direction) and a triangle (three vertices) as packed signed
// Q8.8 vectors; each output beat carries one hit bit for that beat, in order.
// The datapath is an eight-stage pipeline (edges, cross-product terms,
// cross products, dot-product terms, dot products, sign fold, bound checks,
// distance compare), and one beat is taken every cycle except while every
// stage holds a beat behind a held output. Each stage
// has its own valid bit and advances whenever its successor is empty or
// moving, so a held output stalls only the stages behind it and empty stages
// keep filling. Registers det_epsilon (0x0) and dist_epsilon (0x4) are
// written over the APB port and should only change while the pipeline is
// empty.
module ray_triangle_hit_test_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rthit_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rthit_pkg::DATA_W-1:0]  pwdata,
  output logic      [rthit_pkg::DATA_W-1:0]  prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [47:0]                   ray_origin_i,
  input  wire logic [47:0]                   ray_direction_i,
  input  wire logic [47:0]                   vertex_a_i,
  input  wire logic [47:0]                   vertex_b_i,
  input  wire logic [47:0]                   vertex_c_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               hit_o
);

  localparam int unsigned NST = 8;
  localparam int unsigned W_E = rthit_pkg::W_E;
  localparam int unsigned W_H = rthit_pkg::W_H;
  localparam int unsigned W_Q = rthit_pkg::W_Q;
  localparam int unsigned W_P = rthit_pkg::W_P;
  localparam int unsigned W_S = rthit_pkg::W_S;
  localparam int unsigned W_T = rthit_pkg::W_T;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [rthit_pkg::DET_EPS_W-1:0]  det_eps_q;
  logic [rthit_pkg::DIST_EPS_W-1:0] dist_eps_q;
  logic                             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_eps_q  <= rthit_pkg::DET_EPS_RST;
      dist_eps_q <= rthit_pkg::DIST_EPS_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        rthit_pkg::REG_DET_EPS:  det_eps_q  <= pwdata[rthit_pkg::DET_EPS_W-1:0];
        rthit_pkg::REG_DIST_EPS: dist_eps_q <= pwdata[rthit_pkg::DIST_EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      rthit_pkg::REG_DET_EPS:
        prdata = {{(rthit_pkg::DATA_W - rthit_pkg::DET_EPS_W){1'b0}}, det_eps_q};
      rthit_pkg::REG_DIST_EPS:
        prdata = {{(rthit_pkg::DATA_W - rthit_pkg::DIST_EPS_W){1'b0}}, dist_eps_q};
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or its successor
  // advances
  // ---------------------------------------------------------------------
  logic [NST:1] v_q;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v_q[NST] || out_ready_i;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NST];

  // ---------------------------------------------------------------------
  // Stage 1: edges e1 = B - A, e2 = C - A and offset s = O - A
  // ---------------------------------------------------------------------
  rthit_pkg::vec_c_t orig, dir, va, vb, vc;
  rthit_pkg::vec_e_t e1_1_q, e2_1_q, s_1_q;
  rthit_pkg::vec_c_t dir_1_q;

  assign orig = ray_origin_i;
  assign dir  = ray_direction_i;
  assign va   = vertex_a_i;
  assign vb   = vertex_b_i;
  assign vc   = vertex_c_i;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      e1_1_q.x <= W_E'(vb.x) - W_E'(va.x);
      e1_1_q.y <= W_E'(vb.y) - W_E'(va.y);
      e1_1_q.z <= W_E'(vb.z) - W_E'(va.z);
      e2_1_q.x <= W_E'(vc.x) - W_E'(va.x);
      e2_1_q.y <= W_E'(vc.y) - W_E'(va.y);
      e2_1_q.z <= W_E'(vc.z) - W_E'(va.z);
      s_1_q.x  <= W_E'(orig.x) - W_E'(va.x);
      s_1_q.y  <= W_E'(orig.y) - W_E'(va.y);
      s_1_q.z  <= W_E'(orig.z) - W_E'(va.z);
      dir_1_q  <= dir;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: cross-product terms of h = dir x e2 and q = s x e1
  // ---------------------------------------------------------------------
  logic signed [W_H-1:0] hp_2_q [6];
  logic signed [W_Q-1:0] qp_2_q [6];
  rthit_pkg::vec_e_t     e1_2_q, e2_2_q, s_2_q;
  rthit_pkg::vec_c_t     dir_2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      hp_2_q[0] <= W_H'(dir_1_q.y) * W_H'(e2_1_q.z);
      hp_2_q[1] <= W_H'(dir_1_q.z) * W_H'(e2_1_q.y);
      hp_2_q[2] <= W_H'(dir_1_q.z) * W_H'(e2_1_q.x);
      hp_2_q[3] <= W_H'(dir_1_q.x) * W_H'(e2_1_q.z);
      hp_2_q[4] <= W_H'(dir_1_q.x) * W_H'(e2_1_q.y);
      hp_2_q[5] <= W_H'(dir_1_q.y) * W_H'(e2_1_q.x);
      qp_2_q[0] <= W_Q'(s_1_q.y) * W_Q'(e1_1_q.z);
      qp_2_q[1] <= W_Q'(s_1_q.z) * W_Q'(e1_1_q.y);
      qp_2_q[2] <= W_Q'(s_1_q.z) * W_Q'(e1_1_q.x);
      qp_2_q[3] <= W_Q'(s_1_q.x) * W_Q'(e1_1_q.z);
      qp_2_q[4] <= W_Q'(s_1_q.x) * W_Q'(e1_1_q.y);
      qp_2_q[5] <= W_Q'(s_1_q.y) * W_Q'(e1_1_q.x);
      e1_2_q    <= e1_1_q;
      e2_2_q    <= e2_1_q;
      s_2_q     <= s_1_q;
      dir_2_q   <= dir_1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: finish the cross products
  // ---------------------------------------------------------------------
  rthit_pkg::vec_h_t h_3_q;
  rthit_pkg::vec_q_t q_3_q;
  rthit_pkg::vec_e_t e1_3_q, e2_3_q, s_3_q;
  rthit_pkg::vec_c_t dir_3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      h_3_q.x <= hp_2_q[0] - hp_2_q[1];
      h_3_q.y <= hp_2_q[2] - hp_2_q[3];
      h_3_q.z <= hp_2_q[4] - hp_2_q[5];
      q_3_q.x <= qp_2_q[0] - qp_2_q[1];
      q_3_q.y <= qp_2_q[2] - qp_2_q[3];
      q_3_q.z <= qp_2_q[4] - qp_2_q[5];
      e1_3_q  <= e1_2_q;
      e2_3_q  <= e2_2_q;
      s_3_q   <= s_2_q;
      dir_3_q <= dir_2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: dot-product terms of det, nu, nv and nt
  // ---------------------------------------------------------------------
  logic signed [W_P-1:0] dd_4_q [3];
  logic signed [W_P-1:0] du_4_q [3];
  logic signed [W_P-1:0] dv_4_q [3];
  logic signed [W_P-1:0] dt_4_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dd_4_q[0] <= W_P'(e1_3_q.x) * W_P'(h_3_q.x);
      dd_4_q[1] <= W_P'(e1_3_q.y) * W_P'(h_3_q.y);
      dd_4_q[2] <= W_P'(e1_3_q.z) * W_P'(h_3_q.z);
      du_4_q[0] <= W_P'(s_3_q.x) * W_P'(h_3_q.x);
      du_4_q[1] <= W_P'(s_3_q.y) * W_P'(h_3_q.y);
      du_4_q[2] <= W_P'(s_3_q.z) * W_P'(h_3_q.z);
      dv_4_q[0] <= W_P'(dir_3_q.x) * W_P'(q_3_q.x);
      dv_4_q[1] <= W_P'(dir_3_q.y) * W_P'(q_3_q.y);
      dv_4_q[2] <= W_P'(dir_3_q.z) * W_P'(q_3_q.z);
      dt_4_q[0] <= W_P'(e2_3_q.x) * W_P'(q_3_q.x);
      dt_4_q[1] <= W_P'(e2_3_q.y) * W_P'(q_3_q.y);
      dt_4_q[2] <= W_P'(e2_3_q.z) * W_P'(q_3_q.z);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: sum the dot products
  // ---------------------------------------------------------------------
  logic signed [W_S-1:0] det_5_q, nu_5_q, nv_5_q, nt_5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      det_5_q <= W_S'(dd_4_q[0]) + W_S'(dd_4_q[1]) + W_S'(dd_4_q[2]);
      nu_5_q  <= W_S'(du_4_q[0]) + W_S'(du_4_q[1]) + W_S'(du_4_q[2]);
      nv_5_q  <= W_S'(dv_4_q[0]) + W_S'(dv_4_q[1]) + W_S'(dv_4_q[2]);
      nt_5_q  <= W_S'(dt_4_q[0]) + W_S'(dt_4_q[1]) + W_S'(dt_4_q[2]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: fold the sign so det is non-negative; flag a parallel ray
  // ---------------------------------------------------------------------
  logic                  neg5;
  logic signed [W_S-1:0] det_abs5;
  logic signed [W_S-1:0] det_6_q, nu_6_q, nv_6_q, nt_6_q;
  logic                  par_6_q;

  assign neg5     = det_5_q[W_S-1];
  assign det_abs5 = neg5 ? -det_5_q : det_5_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      det_6_q <= det_abs5;
      nu_6_q  <= neg5 ? -nu_5_q : nu_5_q;
      nv_6_q  <= neg5 ? -nv_5_q : nv_5_q;
      nt_6_q  <= neg5 ? -nt_5_q : nt_5_q;
      par_6_q <= $unsigned(det_abs5) < W_S'(det_eps_q);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: barycentric bounds; scale both sides of the distance test
  // ---------------------------------------------------------------------
  logic signed [W_S-1:0]          uv_sum6;
  logic signed [rthit_pkg::DIST_EPS_W:0] dist_s;
  logic                           miss_7_q;
  logic signed [W_T-1:0]          tnum_7_q, tlim_7_q;

  assign uv_sum6 = nu_6_q + nv_6_q;
  assign dist_s  = {1'b0, dist_eps_q};

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      miss_7_q <= par_6_q || nu_6_q[W_S-1] || (nu_6_q > det_6_q) ||
                  nv_6_q[W_S-1] || (uv_sum6 > det_6_q);
      tnum_7_q <= {nt_6_q, 8'b0};
      tlim_7_q <= W_T'(det_6_q) * W_T'(dist_s);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: distance compare into the output register
  // ---------------------------------------------------------------------
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      hit_q <= !miss_7_q && (tnum_7_q > tlim_7_q);
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

### rtl/core/rthit_checker.sv
`default_nettype none

module rthit_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic hit_o
);

  // No result beat is offered while in reset
  a_no_out_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result beat shown during reset");

  // An empty output register means the pipeline can take a beat
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input held off with an empty output stage");

  // A held result beat stays offered
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while held");

  // A held result beat keeps its value
  a_out_hit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hit_o))
    else $error("result changed while held");

endmodule

bind ray_triangle_hit_test_core rthit_checker u_rthit_checker (.*);

`default_nettype wire

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat: ray and triangle, each vector packed z:y:x
  typedef struct {
    logic [47:0] orig;
    logic [47:0] dir;
    logic [47:0] va;
    logic [47:0] vb;
    logic [47:0] vc;
  } ray_t;

  // Predicts the hit bit per ray beat and holds the hits still owed by the block
  class hit_tracker;
    typedef struct {
      longint x;
      longint y;
      longint z;
    } vec_t;

    bit     pending_hits[$];
    longint det_eps;
    longint dist_eps;
    int     errors;
    int     rays;
    int     hits;
    int     misses;

    function new();
      det_eps  = 1;
      dist_eps = 1;
    endfunction

    static function vec_t unpack3(logic [47:0] p);
      vec_t v;
      v.x = $signed(p[15:0]);
      v.y = $signed(p[31:16]);
      v.z = $signed(p[47:32]);
      return v;
    endfunction

    static function vec_t vsub(vec_t a, vec_t b);
      vec_t r;
      r.x = a.x - b.x;
      r.y = a.y - b.y;
      r.z = a.z - b.z;
      return r;
    endfunction

    static function vec_t vcross(vec_t a, vec_t b);
      vec_t r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
    endfunction

    static function longint vdot(vec_t a, vec_t b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    // Exact ray/triangle test, sign folded so det is never negative
    function bit predict_hit(ray_t r);
      vec_t   o, d, a, b, c, e1, e2, h, s, q;
      longint det, nu, nv, nt;
      bit     hit;
      o   = unpack3(r.orig);
      d   = unpack3(r.dir);
      a   = unpack3(r.va);
      b   = unpack3(r.vb);
      c   = unpack3(r.vc);
      e1  = vsub(b, a);
      e2  = vsub(c, a);
      h   = vcross(d, e2);
      det = vdot(e1, h);
      s   = vsub(o, a);
      q   = vcross(s, e1);
      nu  = vdot(s, h);
      nv  = vdot(d, q);
      nt  = vdot(e2, q);
      hit = 1'b1;
      if (det > -det_eps && det < det_eps) hit = 1'b0;
      if (det < 0) begin
        det = -det;
        nu  = -nu;
        nv  = -nv;
        nt  = -nt;
      end
      if (nu < 0 || nu > det) hit = 1'b0;
      if (nv < 0 || nu + nv > det) hit = 1'b0;
      if (!(nt * 256 > dist_eps * det)) hit = 1'b0;
      return hit;
    endfunction

    function void note_ray(ray_t r);
      pending_hits = {pending_hits, predict_hit(r)};
      rays++;
    endfunction

    function void check_hit(logic got);
      bit want;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual hit=%b", $time, got);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (want) hits++;
        else misses++;
        if (got !== want) begin
          $display("%0t: hit mismatch, expected %b, actual %b", $time, want, got);
          errors++;
        end
      end
    endfunction

    function void check_reg(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s readback mismatch, expected 0x%08h, actual 0x%08h",
                 $time, name, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i           = 1'b0;
  logic                           rst_ni;
  logic                           psel            = 1'b0;
  logic                           penable         = 1'b0;
  logic                           pwrite          = 1'b0;
  logic [rthit_pkg::ADDR_W-1:0]   paddr           = '0;
  logic [rthit_pkg::DATA_W-1:0]   pwdata          = '0;
  logic [rthit_pkg::DATA_W-1:0]   prdata;
  logic                           pready;
  logic                           in_valid_i      = 1'b0;
  logic                           in_ready_o;
  logic [47:0]                    ray_origin_i    = '0;
  logic [47:0]                    ray_direction_i = '0;
  logic [47:0]                    vertex_a_i      = '0;
  logic [47:0]                    vertex_b_i      = '0;
  logic [47:0]                    vertex_c_i      = '0;
  logic                           out_valid_o;
  logic                           out_ready_i     = 1'b0;
  logic                           hit_o;

  hit_tracker tracker = new();
  bit         steady;
  bit         held_long;
  int         settings;

  localparam int LONG_HOLD = 64;

  ray_triangle_hit_test_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .ray_origin_i    (ray_origin_i),
    .ray_direction_i (ray_direction_i),
    .vertex_a_i      (vertex_a_i),
    .vertex_b_i      (vertex_b_i),
    .vertex_c_i      (vertex_c_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o)
  );

  always #2 clk_i = ~clk_i;

  // Check every result beat as it leaves
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_hit(hit_o);
  end

  // Bail out if the run hangs
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d hits outstanding", $time, tracker.pending_hits.size());
    $display("simulation failed");
    $finish;
  end

  function automatic logic [47:0] v3(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic int srand(int mag);
    return int'($urandom_range(2 * mag)) - mag;
  endfunction

  function automatic logic [15:0] edge_lane();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [47:0] edge_vec();
    return {edge_lane(), edge_lane(), edge_lane()};
  endfunction

  function automatic logic [47:0] raw_vec();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly rays aimed at the triangle, plus tiny, degenerate, raw and extreme beats
  function automatic ray_t random_ray();
    ray_t r;
    int   kind, mag, u, v;
    int   a[3], b[3], c[3], o[3], d[3], p[3];
    kind = $urandom_range(99);
    if (kind >= 75 && kind < 90) begin
      r.orig = raw_vec();
      r.dir  = raw_vec();
      r.va   = raw_vec();
      r.vb   = raw_vec();
      r.vc   = raw_vec();
      return r;
    end
    if (kind >= 90) begin
      r.orig = edge_vec();
      r.dir  = edge_vec();
      r.va   = edge_vec();
      r.vb   = edge_vec();
      r.vc   = edge_vec();
      return r;
    end
    if (kind >= 50 && kind < 65) begin
      // small coordinates keep det near the parallel threshold
      case ($urandom_range(2))
        0:       mag = 2;
        1:       mag = 8;
        default: mag = 40;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       mag = 64;
        1:       mag = 512;
        default: mag = 4096;
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      a[i] = srand(mag);
      b[i] = srand(mag);
      c[i] = srand(mag);
      o[i] = srand(mag);
      d[i] = srand(mag);
    end
    if (kind < 50 || kind >= 65) begin
      // aim at a point given by barycentric weights in 1/256 steps
      if ($urandom_range(3) == 0) begin
        u = $urandom_range(300);
        v = $urandom_range(300);
      end else begin
        u = $urandom_range(256);
        v = $urandom_range(256 - u);
      end
      for (int i = 0; i < 3; i++) begin
        p[i] = a[i] + (u * (b[i] - a[i]) + v * (c[i] - a[i])) / 256;
        d[i] = p[i] - o[i];
      end
      if ($urandom_range(5) == 0) begin
        for (int i = 0; i < 3; i++) d[i] = -d[i];
      end
      if (kind >= 65) begin
        // collapse the triangle or lay the ray along an edge
        for (int i = 0; i < 3; i++) begin
          if (u[0]) c[i] = 2 * b[i] - a[i];
          else d[i] = b[i] - a[i];
        end
      end
    end
    r.orig = v3(o[0], o[1], o[2]);
    r.dir  = v3(d[0], d[1], d[2]);
    r.va   = v3(a[0], a[1], a[2]);
    r.vb   = v3(b[0], b[1], b[2]);
    r.vc   = v3(c[0], c[1], c[2]);
    return r;
  endfunction

  function automatic ray_t mk_ray(logic [47:0] o, logic [47:0] d, logic [47:0] a,
                                  logic [47:0] b, logic [47:0] c);
    ray_t r;
    r.orig = o;
    r.dir  = d;
    r.va   = a;
    r.vb   = b;
    r.vc   = c;
    return r;
  endfunction

  // Offer one ray beat after a random gap (none while steady) and hold it until taken
  task automatic send_ray(ray_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    ray_origin_i    <= r.orig;
    ray_direction_i <= r.dir;
    vertex_a_i      <= r.va;
    vertex_b_i      <= r.vb;
    vertex_c_i      <= r.vc;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_ray(r);
  endtask

  task automatic send_random(int count);
    for (int k = 0; k < count; k++) begin
      steady = (k % 150) < 30;
      send_ray(random_ray());
    end
    steady = 1'b0;
  endtask

  // Drop valid and let every outstanding hit come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_hits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both thresholds with junk above the field, then read them back
  task automatic set_thresholds(logic [15:0] det, logic [7:0] dist_min);
    logic [31:0] got;
    apb_access(1'b1, rthit_pkg::REG_DET_EPS, {16'($urandom), det}, got);
    apb_access(1'b1, rthit_pkg::REG_DIST_EPS, {24'($urandom), dist_min}, got);
    tracker.det_eps  = det;
    tracker.dist_eps = dist_min;
    apb_access(1'b0, rthit_pkg::REG_DET_EPS, '0, got);
    tracker.check_reg("det_epsilon", {16'h0, det}, got);
    apb_access(1'b0, rthit_pkg::REG_DIST_EPS, '0, got);
    tracker.check_reg("dist_epsilon", {24'h0, dist_min}, got);
    settings++;
  endtask

  // Result side: random stalls, one long hold-off to back the pipeline up
  initial begin : receiver
    int n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held_long && tracker.rays > 400) begin
        held_long = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      n = steady ? 0 : $urandom_range(4);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Stimulus
  initial begin : stimulus
    ray_t        directed[$];
    logic [31:0] got;
    logic [47:0] ta, tb_, tc;
    rst_ni <= 1'b0;
    ta  = v3(0, 0, 0);
    tb_ = v3(256, 0, 0);
    tc  = v3(0, 256, 0);
    // Unit triangle in z = 0, rays along +z unless noted
    directed = {directed, mk_ray(v3(64, 64, -256), v3(0, 0, 256), ta, tb_, tc)};
    directed = {directed, mk_ray(v3(300, 10, -256), v3(0, 0, 256), ta, tb_, tc)};
    directed = {directed, mk_ray(v3(64, -10, -256), v3(0, 0, 256), ta, tb_, tc)};
    directed = {directed, mk_ray(v3(200, 200, -256), v3(0, 0, 256), ta, tb_, tc)};
    // behind the origin
    directed = {directed, mk_ray(v3(64, 64, 256), v3(0, 0, 256), ta, tb_, tc)};
    // parallel to the plane
    directed = {directed, mk_ray(v3(64, 64, -256), v3(256, 0, 0), ta, tb_, tc)};
    // vertex and far edge count as inside
    directed = {directed, mk_ray(v3(0, 0, -256), v3(0, 0, 256), ta, tb_, tc)};
    directed = {directed, mk_ray(v3(128, 128, -256), v3(0, 0, 256), ta, tb_, tc)};
    // opposite winding gives negative det
    directed = {directed, mk_ray(v3(64, 64, -256), v3(0, 0, 256), ta, tc, tb_)};
    // distance exactly at, then just past, the minimum
    directed = {directed, mk_ray(v3(64, 64, -1), v3(0, 0, 256), ta, tb_, tc)};
    directed = {directed, mk_ray(v3(64, 64, -2), v3(0, 0, 256), ta, tb_, tc)};
    // origin on the plane
    directed = {directed, mk_ray(v3(64, 64, 0), v3(0, 0, 256), ta, tb_, tc)};
    // collapsed triangle
    directed = {directed, mk_ray(v3(0, 0, -256), v3(0, 0, 256), v3(100, 100, 100),
                                 v3(100, 100, 100), v3(100, 100, 100))};
    // det of one LSB, right at the parallel threshold
    directed = {directed, mk_ray(v3(0, 0, -1), v3(0, 0, 1), ta, v3(1, 0, 0),
                                 v3(0, 1, 0))};
    // downward ray from above
    directed = {directed, mk_ray(v3(64, 64, 256), v3(0, 0, -256), ta, tb_, tc)};
    // full-scale triangle
    directed = {directed, mk_ray(v3(0, 0, -32768), v3(0, 0, 32767),
                                 v3(-32768, -32768, 0), v3(32767, -32768, 0),
                                 v3(-32768, 32767, 0))};
    // field extremes
    directed = {directed, mk_ray('0, '0, '0, '0, '0)};
    directed = {directed, mk_ray('1, '1, '1, '1, '1)};
    directed = {directed, mk_ray({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                                 {3{16'h8000}}, {3{16'h8000}})};
    directed = {directed, mk_ray({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                                 {3{16'h7FFF}}, {3{16'h7FFF}})};
    directed = {directed, mk_ray({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}},
                                 {3{16'h7FFF}}, {16'h0001, 16'h7FFF, 16'h8000})};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of both thresholds
    apb_access(1'b0, rthit_pkg::REG_DET_EPS, '0, got);
    tracker.check_reg("det_epsilon", 32'(rthit_pkg::DET_EPS_RST), got);
    apb_access(1'b0, rthit_pkg::REG_DIST_EPS, '0, got);
    tracker.check_reg("dist_epsilon", 32'(rthit_pkg::DIST_EPS_RST), got);
    settings = 1;

    foreach (directed[i]) send_ray(directed[i]);
    send_random(250);
    drain();

    set_thresholds(16'h0000, 8'h00);
    send_random(200);
    drain();

    set_thresholds(16'hFFFF, 8'hFF);
    send_random(200);
    drain();

    set_thresholds(16'($urandom_range(64)), 8'($urandom_range(255)));
    send_random(200);
    drain();

    set_thresholds(16'($urandom), 8'($urandom_range(255)));
    send_random(200);
    drain();

    foreach (tracker.pending_hits[i]) begin
      $display("%0t: hit never returned, expected %b, actual none", $time,
               tracker.pending_hits[i]);
      tracker.errors++;
    end

    $display("Covered %0d ray beats under %0d threshold settings: %0d hits, %0d misses.",
             tracker.rays, settings, tracker.hits, tracker.misses);
    $display("Included aimed, tiny, degenerate and extreme rays and a %0d-cycle output hold.",
             LONG_HOLD);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
